// ===== hw/rtl/thc_pkg.sv =====
// Shared types, constants and helpers for the temperature/humidity compensation block.
`default_nettype none
package thc_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_TEMP_CAL_ONE    = 3'd0;
   localparam logic [2:0] REG_TEMP_CAL_TWO    = 3'd1;
   localparam logic [2:0] REG_TEMP_CAL_THREE  = 3'd2;
   localparam logic [2:0] REG_HUM_CAL_ONE     = 3'd3;
   localparam logic [2:0] REG_HUM_CAL_TWO     = 3'd4;
   localparam logic [2:0] REG_HUM_CAL_THREE   = 3'd5;
   localparam logic [2:0] REG_HUM_CAL_PACKED  = 3'd6;
   localparam logic [2:0] REG_ALARM_THRESHOLD = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [15:0] ALARM_RESET    = 16'd3000;
   localparam logic [31:0] FINE_OFFSET    = 32'd76800;
   localparam logic [31:0] ROUND_15       = 32'd16384;
   localparam logic [31:0] BIAS_15        = 32'd32768;
   localparam logic [31:0] BIAS_21        = 32'd2097152;
   localparam logic [31:0] ROUND_14       = 32'd8192;
   localparam logic [31:0] ROUND_8        = 32'd128;
   localparam logic [31:0] HUM_CLAMP_MAX  = 32'd419430400;
   localparam logic [16:0] HUM_OUT_MAX    = 17'd102400;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [15:0] raw_humidity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] fine_temperature;
      logic signed [31:0] temperature_centi;
      logic        [16:0] humidity_q10;
      logic               over_threshold;
   } rsp_type;

   // calibration set, fields at their stored widths
   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [7:0]  h1;
      logic [15:0] h2;
      logic [7:0]  h3;
      logic [11:0] h4;
      logic [11:0] h5;
      logic [7:0]  h6;
      logic [15:0] thr;
   } cfg_type;

   // all calibration fields zero, threshold (the low 16 bits) at its reset level
   localparam cfg_type CFG_RESET = {112'd0, ALARM_RESET};

   // temperature path to humidity path
   typedef struct packed {
      logic [31:0] fine;
      logic [31:0] x;
      logic [15:0] raw_humidity;
   } fine_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx12(input logic [11:0] v);
      return {{20{v[11]}}, v};
   endfunction

   function automatic logic [31:0] sx8(input logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/temp_humidity_compensation_unit.sv =====
// Pipeline: 3 temperature + 7 humidity stages between the req accepting edge and rsp_valid.
// Throughput: one item per cycle; up to 10 items in flight, and a stall at rsp
// holds every stage through the per-stage ready chain.
// Reset (synchronous, active high) empties the pipeline and loads all calibration
// registers with 0 and the alarm threshold with 3000.
// Top level of the temperature and humidity compensation block.
`default_nettype none
module temp_humidity_compensation_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  thc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output thc_pkg::rsp_type                 rsp_data,
   input  wire                              csr_write_en,
   input  wire [thc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire [thc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   thc_pkg::cfg_type  cfg;
   thc_pkg::fine_type fine_data;
   logic              fine_valid;
   logic              fine_ready;

   thc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   thc_temp_path u_temp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (fine_valid),
      .out_ready (fine_ready),
      .out_data  (fine_data)
   );

   thc_hum_path u_hum (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (fine_valid),
      .in_ready  (fine_ready),
      .in_data   (fine_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/thc_csr.sv =====
// Calibration and alarm register file with a write-only port.
`default_nettype none
module thc_csr (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_write_en,
   input  wire [thc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire [thc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output thc_pkg::cfg_type                 cfg
);

   thc_pkg::cfg_type cfg_ff;
   thc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            thc_pkg::REG_TEMP_CAL_ONE:    cfg_in.t1  = csr_wdata[15:0];
            thc_pkg::REG_TEMP_CAL_TWO:    cfg_in.t2  = csr_wdata[15:0];
            thc_pkg::REG_TEMP_CAL_THREE:  cfg_in.t3  = csr_wdata[15:0];
            thc_pkg::REG_HUM_CAL_ONE:     cfg_in.h1  = csr_wdata[7:0];
            thc_pkg::REG_HUM_CAL_TWO:     cfg_in.h2  = csr_wdata[15:0];
            thc_pkg::REG_HUM_CAL_THREE:   cfg_in.h3  = csr_wdata[7:0];
            thc_pkg::REG_HUM_CAL_PACKED: begin
               cfg_in.h4 = csr_wdata[11:0];
               cfg_in.h5 = csr_wdata[23:12];
               cfg_in.h6 = csr_wdata[31:24];
            end
            thc_pkg::REG_ALARM_THRESHOLD: cfg_in.thr = csr_wdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= thc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/thc_temp_path.sv =====
// Three-stage temperature pipeline: linear and square terms, fine temperature.
`default_nettype none
module thc_temp_path (
   input  wire                 clock,
   input  wire                 reset,
   input  thc_pkg::cfg_type    cfg,
   input  wire                 in_valid,
   output logic                in_ready,
   input  thc_pkg::req_type    in_data,
   output logic                out_valid,
   input  wire                 out_ready,
   output thc_pkg::fine_type   out_data
);

   localparam int NumStages = 3;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] move;

   // stage 1
   logic [31:0] plin_ff, plin_in;
   logic [31:0] dd_ff, dd_in;
   logic [15:0] rh1_ff;
   // stage 2
   logic [31:0] lin_ff, lin_in;
   logic [31:0] sq_ff, sq_in;
   logic [15:0] rh2_ff;
   // stage 3
   thc_pkg::fine_type out_ff, out_in;

   logic [31:0] lin_arg;
   logic [31:0] diff;
   logic [31:0] fine;

   always_comb begin
      move[NumStages-1] = !valid_ff[NumStages-1] || out_ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         move[k] = !valid_ff[k] || move[k+1];
      end
      valid_in[0] = move[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NumStages; k++) begin
         valid_in[k] = move[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_comb begin
      lin_arg = {15'd0, in_data.raw_temperature[19:3]} - {15'd0, cfg.t1, 1'b0};
      diff    = {16'd0, in_data.raw_temperature[19:4]} - {16'd0, cfg.t1};
      plin_in = lin_arg * thc_pkg::sx16(cfg.t2);
      dd_in   = diff * diff;

      lin_in  = 32'($signed(plin_ff) >>> 11);
      sq_in   = 32'($signed(dd_ff) >>> 12) * thc_pkg::sx16(cfg.t3);

      fine                  = lin_ff + 32'($signed(sq_ff) >>> 14);
      out_in.fine           = fine;
      out_in.x              = fine - thc_pkg::FINE_OFFSET;
      out_in.raw_humidity   = rh2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move[0]) begin
         plin_ff <= plin_in;
         dd_ff   <= dd_in;
         rh1_ff  <= in_data.raw_humidity;
      end
      if (move[1]) begin
         lin_ff <= lin_in;
         sq_ff  <= sq_in;
         rh2_ff <= rh1_ff;
      end
      if (move[2]) begin
         out_ff <= out_in;
      end
   end

   assign in_ready  = move[0];
   assign out_valid = valid_ff[NumStages-1];
   assign out_data  = out_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/thc_hum_path.sv =====
// Seven-stage humidity pipeline with centi-degree conversion, alarm and clamp.
`default_nettype none
module thc_hum_path (
   input  wire                 clock,
   input  wire                 reset,
   input  thc_pkg::cfg_type    cfg,
   input  wire                 in_valid,
   output logic                in_ready,
   input  thc_pkg::fine_type   in_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output thc_pkg::rsp_type    rsp_data
);

   localparam int NumStages = 7;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] move;

   // fine temperature rides along every stage
   logic [31:0] fine_ff [NumStages-1];
   // stage 1
   logic [31:0] c5_ff, c5_in;
   logic [31:0] h5x_ff, h5x_in;
   logic [31:0] xh6_ff, xh6_in;
   logic [31:0] xh3_ff, xh3_in;
   logic [15:0] rh_ff;
   // stage 2 onward
   logic [31:0] centi_ff [1:5];
   logic        over_ff [1:5];
   logic [31:0] centi_in;
   logic        over_in;
   logic [31:0] a_ff [1:2];
   logic [31:0] a_in;
   logic [31:0] b1_ff, b1_in;
   // stage 3
   logic [31:0] b2_ff, b2_in;
   // stage 4..6
   logic [31:0] h_ff [3:5];
   logic [31:0] h_in;
   logic [31:0] ss_ff, ss_in;
   logic [31:0] tq_ff, tq_in;
   // output
   thc_pkg::rsp_type rsp_ff, rsp_in;

   logic [31:0] a_sum;
   logic [31:0] s;
   logic [31:0] hf;
   logic [31:0] hum;

   always_comb begin
      move[NumStages-1] = !valid_ff[NumStages-1] || rsp_ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         move[k] = !valid_ff[k] || move[k+1];
      end
      valid_in[0] = move[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NumStages; k++) begin
         valid_in[k] = move[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_comb begin
      // stage 1: fine*5 + 128 and the three x products
      c5_in  = {in_data.fine[29:0], 2'b00} + in_data.fine + thc_pkg::ROUND_8;
      h5x_in = thc_pkg::sx12(cfg.h5) * in_data.x;
      xh6_in = in_data.x * thc_pkg::sx8(cfg.h6);
      xh3_in = in_data.x * {24'd0, cfg.h3};

      // stage 2
      centi_in = 32'($signed(c5_ff) >>> 8);
      over_in  = $signed(centi_in) >= $signed(thc_pkg::sx16(cfg.thr));
      a_sum    = {2'b00, rh_ff, 14'd0} - {cfg.h4, 20'd0} - h5x_ff + thc_pkg::ROUND_15;
      a_in     = 32'($signed(a_sum) >>> 15);
      b1_in    = 32'($signed(xh6_ff) >>> 10)
                 * (32'($signed(xh3_ff) >>> 11) + thc_pkg::BIAS_15);

      // stage 3
      b2_in = (32'($signed(b1_ff) >>> 10) + thc_pkg::BIAS_21) * thc_pkg::sx16(cfg.h2)
              + thc_pkg::ROUND_14;

      // stage 4
      h_in = a_ff[2] * 32'($signed(b2_ff) >>> 14);

      // stage 5
      s     = 32'($signed(h_ff[3]) >>> 15);
      ss_in = s * s;

      // stage 6
      tq_in = 32'($signed(ss_ff) >>> 7) * {24'd0, cfg.h1};

      // stage 7: square correction, clamp, Q7.10
      hf = h_ff[5] - 32'($signed(tq_ff) >>> 4);
      if (hf[31]) begin
         hum = '0;
      end else if (hf > thc_pkg::HUM_CLAMP_MAX) begin
         hum = thc_pkg::HUM_CLAMP_MAX;
      end else begin
         hum = hf;
      end
      rsp_in.fine_temperature  = fine_ff[5];
      rsp_in.temperature_centi = centi_ff[5];
      rsp_in.humidity_q10      = hum[28:12];
      rsp_in.over_threshold    = over_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move[0]) begin
         fine_ff[0] <= in_data.fine;
         rh_ff      <= in_data.raw_humidity;
         c5_ff      <= c5_in;
         h5x_ff     <= h5x_in;
         xh6_ff     <= xh6_in;
         xh3_ff     <= xh3_in;
      end
      if (move[1]) begin
         fine_ff[1]  <= fine_ff[0];
         centi_ff[1] <= centi_in;
         over_ff[1]  <= over_in;
         a_ff[1]     <= a_in;
         b1_ff       <= b1_in;
      end
      if (move[2]) begin
         fine_ff[2]  <= fine_ff[1];
         centi_ff[2] <= centi_ff[1];
         over_ff[2]  <= over_ff[1];
         a_ff[2]     <= a_ff[1];
         b2_ff       <= b2_in;
      end
      if (move[3]) begin
         fine_ff[3]  <= fine_ff[2];
         centi_ff[3] <= centi_ff[2];
         over_ff[3]  <= over_ff[2];
         h_ff[3]     <= h_in;
      end
      if (move[4]) begin
         fine_ff[4]  <= fine_ff[3];
         centi_ff[4] <= centi_ff[3];
         over_ff[4]  <= over_ff[3];
         h_ff[4]     <= h_ff[3];
         ss_ff       <= ss_in;
      end
      if (move[5]) begin
         fine_ff[5]  <= fine_ff[4];
         centi_ff[5] <= centi_ff[4];
         over_ff[5]  <= over_ff[4];
         h_ff[5]     <= h_ff[4];
         tq_ff       <= tq_in;
      end
      if (move[6]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign in_ready  = move[0];
   assign rsp_valid = valid_ff[NumStages-1];
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // clamp keeps the Q7.10 value in range
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.humidity_q10 <= thc_pkg::HUM_OUT_MAX)
      else $error("humidity above clamp");

   // alarm flag agrees with the delivered temperature
   a_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.over_threshold ==
         ($signed(rsp_data.temperature_centi) >= $signed(thc_pkg::sx16(cfg.thr))))
      else $error("alarm flag mismatch");

   // a full, stalled pipe takes nothing new
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !rsp_ready |-> !in_ready)
      else $error("item taken into full pipe");

   // a held stage keeps its item
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] && !move[3] |=> valid_ff[3])
      else $error("stalled item dropped");
`endif

endmodule
`default_nettype wire
